>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL; both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock edge outside reset
`define MPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition in one cycle implies a condition in the next
`define MPM_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> hdl/mpm_pkg.sv
package mpm_pkg;

	// default word format: Q16.16
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;

	// coefficient register file
	localparam int NUM_COEF     = 8;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_A_RE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_A_IM = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_RE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_B_IM = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_RE = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_C_IM = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_D_RE = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_D_IM = 3'd7;

	// flags that travel with one lane through the divider chain
	typedef struct packed {
		logic neg;
		logic over;
		logic pole;
	} div_flag_t;

endpackage

>>> hdl/mpm_in_if.sv
interface mpm_in_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] point_re;
	logic signed [W-1:0] point_im;
	logic                use_inverse;

	modport source (output valid, output point_re, output point_im, output use_inverse,
		input ready);
	modport sink (input valid, input point_re, input point_im, input use_inverse,
		output ready);
endinterface

>>> hdl/mpm_out_if.sv
interface mpm_out_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] image_re;
	logic signed [W-1:0] image_im;
	logic                at_pole;
	logic                clipped;

	modport source (output valid, output image_re, output image_im, output at_pole,
		output clipped, input ready);
	modport sink (input valid, input image_re, input image_im, input at_pole,
		input clipped, output ready);
endinterface

>>> hdl/mpm_cfg.sv
module mpm_cfg
	import mpm_pkg::*;
#(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_IDX_BITS-1:0]          cfg_idx,
	input  logic [W-1:0]                     cfg_data,
	output logic [NUM_COEF-1:0][W-1:0]       coef_q
);

	localparam logic [W-1:0] ONE = W'(1) << F;

	// coefficient registers, a and d reset to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= (i == int'(REG_A_RE) || i == int'(REG_D_RE)) ? ONE : '0;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_A_RE: coef_q[REG_A_RE] <= cfg_data;
				REG_A_IM: coef_q[REG_A_IM] <= cfg_data;
				REG_B_RE: coef_q[REG_B_RE] <= cfg_data;
				REG_B_IM: coef_q[REG_B_IM] <= cfg_data;
				REG_C_RE: coef_q[REG_C_RE] <= cfg_data;
				REG_C_IM: coef_q[REG_C_IM] <= cfg_data;
				REG_D_RE: coef_q[REG_D_RE] <= cfg_data;
				REG_D_IM: coef_q[REG_D_IM] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/mpm_mul.sv
module mpm_mul #(
	parameter int WA = 32
) (
	input  logic                   clk,
	input  logic [1:0]             en,
	input  logic signed [WA-1:0]   a,
	input  logic signed [WA-1:0]   b,
	output logic signed [2*WA-1:0] p_s2
);

	localparam int LB = WA / 2;
	localparam int HB = WA - LB;
	localparam int PW = 2 * WA;

	logic signed [HB-1:0]      a_hi, b_hi;
	logic        [LB-1:0]      a_lo, b_lo;
	logic signed [2*HB-1:0]    pp_hh_s1;
	logic signed [HB+LB:0]     pp_hl_s1, pp_lh_s1;
	logic        [2*LB-1:0]    pp_ll_s1;

	assign a_hi = a[WA-1:LB];
	assign b_hi = b[WA-1:LB];
	assign a_lo = a[LB-1:0];
	assign b_lo = b[LB-1:0];

	// four half-width partial products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pp_hh_s1 <= a_hi * b_hi;
			pp_hl_s1 <= a_hi * $signed({1'b0, b_lo});
			pp_lh_s1 <= $signed({1'b0, a_lo}) * b_hi;
			pp_ll_s1 <= a_lo * b_lo;
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2 <= (PW'(pp_hh_s1) <<< (2 * LB)) + (PW'(pp_hl_s1) <<< LB)
				+ (PW'(pp_lh_s1) <<< LB) + PW'($signed({1'b0, pp_ll_s1}));
		end
	end

endmodule

>>> hdl/mpm_div_cell.sv
module mpm_div_cell
	import mpm_pkg::*;
#(
	parameter int RB  = 200,
	parameter int DB  = 140,
	parameter int W   = 32,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RB-1:0] rem,
	input  logic [DB-1:0] den,
	input  logic [W-1:0]  quo,
	input  div_flag_t     flg,
	output logic [RB-1:0] rem_s1,
	output logic [DB-1:0] den_s1,
	output logic [W-1:0]  quo_s1,
	output div_flag_t     flg_s1
);

	logic [RB-1:0] sh;
	logic          ge;
	logic [W-1:0]  quo_n;

	// one restoring step: try the divisor at this bit weight
	always_comb begin
		sh       = RB'(den) << BIT;
		ge       = rem >= sh;
		quo_n    = quo;
		quo_n[BIT] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? (rem - sh) : rem;
			den_s1 <= den;
			quo_s1 <= quo_n;
			flg_s1 <= flg;
		end
	end

endmodule

>>> hdl/mobius_point_map_top.sv
// Word format: Q16.16 by default (FRAC_BITS fraction bits in a WORD_BITS word).
// Throughput: one request per cycle while the output is not held; the long quotient runs
// through a row of WORD_BITS divider cells, one quotient bit per cell, so every stage holds its own item.
// Stalls on the output collapse bubbles stage by stage; input is taken while any stage frees.
// Reset: asynchronous, active low; clears all stage valid bits and loads the
// coefficients with the identity map (a = d = 1.0, b = c = 0).
module mobius_point_map_top
	import mpm_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [WORD_BITS-1:0]     cfg_data,
	mpm_in_if.sink                   pt_ch,
	mpm_out_if.source                img_ch
);

	`include "assert_macros.svh"

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int NB = ((2 * W > W + F) ? 2 * W : W + F) + 2;
	localparam int PB = 2 * NB + 1;
	localparam int RB = PB + F + W;
	localparam int CS = 9;
	localparam int L  = W + CS;

	// stage control: a stage moves when it is empty or its successor moves
	logic [L+1:1] adv;
	logic [L:1]   v;

	assign adv[L+1] = img_ch.ready;
	genvar gk;
	generate
		for (gk = 1; gk <= L; gk++) begin : g_adv
			assign adv[gk] = !v[gk] || adv[gk+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (adv[1]) begin
				v[1] <= pt_ch.valid;
			end
			for (int k = 2; k <= L; k++) begin
				if (adv[k]) begin
					v[k] <= v[k-1];
				end
			end
		end
	end

	assign pt_ch.ready = adv[1];

	// coefficient registers
	logic [NUM_COEF-1:0][W-1:0] coef_q;

	mpm_cfg #(.W(W), .F(F)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.coef_q  (coef_q)
	);

	// s1: capture point, pick coefficients for the direction
	logic signed [W-1:0] z_re_s1, z_im_s1, m_re_s1, m_im_s1, c_re_s1, c_im_s1;
	logic signed [W-1:0] b_re_s1, b_im_s1, e_re_s1, e_im_s1;
	logic                inv_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			z_re_s1 <= pt_ch.point_re;
			z_im_s1 <= pt_ch.point_im;
			inv_s1  <= pt_ch.use_inverse;
			m_re_s1 <= pt_ch.use_inverse ? coef_q[REG_D_RE] : coef_q[REG_A_RE];
			m_im_s1 <= pt_ch.use_inverse ? coef_q[REG_D_IM] : coef_q[REG_A_IM];
			e_re_s1 <= pt_ch.use_inverse ? coef_q[REG_A_RE] : coef_q[REG_D_RE];
			e_im_s1 <= pt_ch.use_inverse ? coef_q[REG_A_IM] : coef_q[REG_D_IM];
			c_re_s1 <= coef_q[REG_C_RE];
			c_im_s1 <= coef_q[REG_C_IM];
			b_re_s1 <= coef_q[REG_B_RE];
			b_im_s1 <= coef_q[REG_B_IM];
		end
	end

	// s2..s3: the eight products m*z and c*z
	logic signed [W-1:0]   m1_a [8];
	logic signed [W-1:0]   m1_b [8];
	logic signed [2*W-1:0] mp   [8];

	always_comb begin
		m1_a[0] = m_re_s1; m1_b[0] = z_re_s1;
		m1_a[1] = m_im_s1; m1_b[1] = z_im_s1;
		m1_a[2] = m_re_s1; m1_b[2] = z_im_s1;
		m1_a[3] = m_im_s1; m1_b[3] = z_re_s1;
		m1_a[4] = c_re_s1; m1_b[4] = z_re_s1;
		m1_a[5] = c_im_s1; m1_b[5] = z_im_s1;
		m1_a[6] = c_re_s1; m1_b[6] = z_im_s1;
		m1_a[7] = c_im_s1; m1_b[7] = z_re_s1;
	end

	generate
		for (gk = 0; gk < 8; gk++) begin : g_mul1
			mpm_mul #(.WA(W)) u_mul (
				.clk (clk),
				.en  ({adv[3], adv[2]}),
				.a   (m1_a[gk]),
				.b   (m1_b[gk]),
				.p_s2(mp[gk])
			);
		end
	endgenerate

	logic signed [W-1:0] b_re_s2, b_im_s2, e_re_s2, e_im_s2;
	logic signed [W-1:0] b_re_s3, b_im_s3, e_re_s3, e_im_s3;
	logic                inv_s2, inv_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			b_re_s2 <= b_re_s1; b_im_s2 <= b_im_s1;
			e_re_s2 <= e_re_s1; e_im_s2 <= e_im_s1;
			inv_s2  <= inv_s1;
		end
		if (adv[3]) begin
			b_re_s3 <= b_re_s2; b_im_s3 <= b_im_s2;
			e_re_s3 <= e_re_s2; e_im_s3 <= e_im_s2;
			inv_s3  <= inv_s2;
		end
	end

	// s4: numerator and denominator, exact at the product scale
	logic signed [NB-1:0] b_re_sh, b_im_sh, e_re_sh, e_im_sh, t_re, t_im;
	logic signed [NB-1:0] n_re_s4, n_im_s4, d_re_s4, d_im_s4;
	logic                 pole_s4;

	always_comb begin
		b_re_sh = NB'(b_re_s3) <<< F;
		b_im_sh = NB'(b_im_s3) <<< F;
		e_re_sh = NB'(e_re_s3) <<< F;
		e_im_sh = NB'(e_im_s3) <<< F;
		t_re    = NB'(mp[4]) - NB'(mp[5]);
		t_im    = NB'(mp[6]) + NB'(mp[7]);
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			n_re_s4 <= NB'(mp[0]) - NB'(mp[1]) + (inv_s3 ? -b_re_sh : b_re_sh);
			n_im_s4 <= NB'(mp[2]) + NB'(mp[3]) + (inv_s3 ? -b_im_sh : b_im_sh);
			d_re_s4 <= (inv_s3 ? -t_re : t_re) + e_re_sh;
			d_im_s4 <= (inv_s3 ? -t_im : t_im) + e_im_sh;
			pole_s4 <= ((inv_s3 ? -t_re : t_re) + e_re_sh == '0)
				&& ((inv_s3 ? -t_im : t_im) + e_im_sh == '0);
		end
	end

	// s5..s6: conj(D) * N and |D|^2 products
	logic signed [NB-1:0]   m2_a [6];
	logic signed [NB-1:0]   m2_b [6];
	logic signed [2*NB-1:0] mq   [6];

	always_comb begin
		m2_a[0] = n_re_s4; m2_b[0] = d_re_s4;
		m2_a[1] = n_im_s4; m2_b[1] = d_im_s4;
		m2_a[2] = n_im_s4; m2_b[2] = d_re_s4;
		m2_a[3] = n_re_s4; m2_b[3] = d_im_s4;
		m2_a[4] = d_re_s4; m2_b[4] = d_re_s4;
		m2_a[5] = d_im_s4; m2_b[5] = d_im_s4;
	end

	generate
		for (gk = 0; gk < 6; gk++) begin : g_mul2
			mpm_mul #(.WA(NB)) u_mul (
				.clk (clk),
				.en  ({adv[6], adv[5]}),
				.a   (m2_a[gk]),
				.b   (m2_b[gk]),
				.p_s2(mq[gk])
			);
		end
	endgenerate

	logic pole_s5, pole_s6, pole_s7;

	always_ff @(posedge clk) begin
		if (adv[5]) pole_s5 <= pole_s4;
		if (adv[6]) pole_s6 <= pole_s5;
	end

	// s7: dividends for both parts and the divisor
	logic signed [PB-1:0] p_s7 [2];
	logic        [PB-1:0] mag_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			p_s7[0] <= PB'(mq[0]) + PB'(mq[1]);
			p_s7[1] <= PB'(mq[2]) - PB'(mq[3]);
			mag_s7  <= PB'(mq[4]) + PB'(mq[5]);
			pole_s7 <= pole_s6;
		end
	end

	// s8: magnitude, scale by the fraction, early overflow check
	logic [RB-1:0]  c_rem [2][W+1];
	logic [PB-1:0]  c_den [2][W+1];
	logic [W-1:0]   c_quo [2][W+1];
	div_flag_t      c_flg [2][W+1];
	logic [PB-1:0]  abs_p [2];
	logic [RB-1:0]  x_val [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			abs_p[l] = p_s7[l][PB-1] ? PB'(-p_s7[l]) : PB'(p_s7[l]);
			x_val[l] = RB'(abs_p[l]) << F;
		end
	end

	generate
		for (gk = 0; gk < 2; gk++) begin : g_s8
			always_ff @(posedge clk) begin
				if (adv[8]) begin
					c_rem[gk][0]      <= x_val[gk];
					c_den[gk][0]      <= mag_s7;
					c_quo[gk][0]      <= '0;
					c_flg[gk][0].neg  <= p_s7[gk][PB-1];
					c_flg[gk][0].over <= x_val[gk] >= (RB'(mag_s7) << W);
					c_flg[gk][0].pole <= pole_s7;
				end
			end
		end
	endgenerate

	// divider cells, most significant quotient bit first
	genvar gl;
	generate
		for (gl = 0; gl < 2; gl++) begin : g_lane
			for (gk = 0; gk < W; gk++) begin : g_cell
				mpm_div_cell #(.RB(RB), .DB(PB), .W(W), .BIT(W - 1 - gk)) u_cell (
					.clk   (clk),
					.en    (adv[CS + gk]),
					.rem   (c_rem[gl][gk]),
					.den   (c_den[gl][gk]),
					.quo   (c_quo[gl][gk]),
					.flg   (c_flg[gl][gk]),
					.rem_s1(c_rem[gl][gk+1]),
					.den_s1(c_den[gl][gk+1]),
					.quo_s1(c_quo[gl][gk+1]),
					.flg_s1(c_flg[gl][gk+1])
				);
			end
		end
	endgenerate

	// final stage: round half away from zero, saturate, apply sign
	logic [W:0]   res_m [2];
	logic [W:0]   lim   [2];
	logic [W:0]   sat_m [2];
	logic         sat   [2];
	logic         up    [2];
	logic [W-1:0] img   [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			up[l]    = {c_rem[l][W], 1'b0} >= {1'b0, RB'(c_den[l][W])};
			res_m[l] = (W + 1)'(c_quo[l][W]) + (W + 1)'(up[l]);
			lim[l]   = ((W + 1)'(1) << (W - 1)) - (W + 1)'(!c_flg[l][W].neg);
			sat[l]   = c_flg[l][W].over || (res_m[l] > lim[l]);
			sat_m[l] = sat[l] ? lim[l] : res_m[l];
			img[l]   = c_flg[l][W].neg ? W'(-sat_m[l]) : W'(sat_m[l]);
		end
	end

	logic [W-1:0] out_re_q, out_im_q;
	logic         out_pole_q, out_clip_q;

	always_ff @(posedge clk) begin
		if (adv[L]) begin
			out_pole_q <= c_flg[0][W].pole;
			out_re_q   <= c_flg[0][W].pole ? '0 : img[0];
			out_im_q   <= c_flg[0][W].pole ? '0 : img[1];
			out_clip_q <= !c_flg[0][W].pole && (sat[0] || sat[1]);
		end
	end

	assign img_ch.valid    = v[L];
	assign img_ch.image_re = out_re_q;
	assign img_ch.image_im = out_im_q;
	assign img_ch.at_pole  = out_pole_q;
	assign img_ch.clipped  = out_clip_q;

	localparam logic [W-1:0] MAX_W = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] MIN_W = {1'b1, {(W - 1){1'b0}}};

	// input is refused only when every stage is full and the output is held
	`MPM_ASSERT(a_ready_full, !pt_ch.ready |-> (v == {L{1'b1}} && !img_ch.ready), "input stalled with a free stage")
	// a pole result carries zero parts and no clip
	`MPM_ASSERT(a_pole_zero, img_ch.valid && img_ch.at_pole |-> (img_ch.clipped == 1'b0 && out_re_q == '0 && out_im_q == '0), "pole result not cleared")
	// a clipped result has at least one part at a word limit
	`MPM_ASSERT(a_clip_edge, img_ch.valid && img_ch.clipped |-> (out_re_q == MAX_W || out_re_q == MIN_W || out_im_q == MAX_W || out_im_q == MIN_W), "clip flag without a saturated part")
	// a full first stage that cannot move keeps its request
	`MPM_ASSERT_NEXT(a_s1_hold, v[1] && !adv[1], v[1] && $stable(z_re_s1), "first stage lost its request")

endmodule
